// ===== rtl/dh_geometric_jacobian_column_unit_assert.svh =====
// Assertion macros shared by the Jacobian column unit.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef DH_GEOMETRIC_JACOBIAN_COLUMN_UNIT_ASSERT_SVH
`define DH_GEOMETRIC_JACOBIAN_COLUMN_UNIT_ASSERT_SVH

// same-cycle implication
`define DHJ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DHJ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dhj_pkg.sv =====
// Shared types, constants and helper functions for the Jacobian column unit.
// No dependencies.
`default_nettype none
package dhj_pkg;
	localparam int MAX_JOINTS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 24;

	localparam logic signed [34:0] PI_Q28      = 35'sd843314857;
	localparam logic signed [34:0] TWO_PI_Q28  = 35'sd1686629713;
	localparam logic signed [34:0] HALF_PI_Q28 = 35'sd421657428;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;

	typedef enum logic [3:0] {
		OP_NOP, OP_LOAD, OP_REDUCE, OP_FOLD, OP_STEP, OP_CAPTURE,
		OP_LINK, OP_ROT, OP_POS, OP_CROSS, OP_COMMIT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [4:0] step;
		logic [1:0] ri;
		logic [1:0] rj;
		logic [1:0] rk;
	} cmd_t;

	typedef struct packed {
		logic in_range;
		logic out_busy;
	} status_t;

	function automatic logic [31:0] atan_q30(input logic [4:0] idx);
		case (idx)
			5'd0:  atan_q30 = 32'h3243F6A8;
			5'd1:  atan_q30 = 32'h1DAC6705;
			5'd2:  atan_q30 = 32'h0FADBAFC;
			5'd3:  atan_q30 = 32'h07F56EA6;
			5'd4:  atan_q30 = 32'h03FEAB76;
			5'd5:  atan_q30 = 32'h01FFD55B;
			5'd6:  atan_q30 = 32'h00FFFAAA;
			5'd7:  atan_q30 = 32'h007FFF55;
			5'd8:  atan_q30 = 32'h003FFFEA;
			5'd9:  atan_q30 = 32'h001FFFFD;
			5'd10: atan_q30 = 32'h000FFFFF;
			5'd11: atan_q30 = 32'h0007FFFF;
			5'd12: atan_q30 = 32'h0003FFFF;
			5'd13: atan_q30 = 32'h0001FFFF;
			5'd14: atan_q30 = 32'h0000FFFF;
			5'd15: atan_q30 = 32'h00007FFF;
			5'd16: atan_q30 = 32'h00003FFF;
			5'd17: atan_q30 = 32'h00001FFF;
			5'd18: atan_q30 = 32'h00000FFF;
			5'd19: atan_q30 = 32'h000007FF;
			5'd20: atan_q30 = 32'h000003FF;
			5'd21: atan_q30 = 32'h000001FF;
			5'd22: atan_q30 = 32'h000000FF;
			5'd23: atan_q30 = 32'h0000007F;
			5'd24: atan_q30 = 32'h0000003F;
			5'd25: atan_q30 = 32'h0000001F;
			5'd26: atan_q30 = 32'h0000000F;
			5'd27: atan_q30 = 32'h00000008;
			5'd28: atan_q30 = 32'h00000004;
			5'd29: atan_q30 = 32'h00000002;
			5'd30: atan_q30 = 32'h00000001;
			default: atan_q30 = 32'h00000000;
		endcase
	endfunction

	// row-major index into a 3x3 matrix
	function automatic logic [3:0] idx9(input logic [1:0] r, input logic [1:0] c);
		idx9 = {1'b0, r, 1'b0} + {2'b00, r} + {2'b00, c};
	endfunction

	function automatic logic [1:0] next3(input logic [1:0] v);
		case (v)
			2'd0: next3 = 2'd1;
			2'd1: next3 = 2'd2;
			default: next3 = 2'd0;
		endcase
	endfunction

	function automatic logic over32(input logic signed [67:0] v);
		over32 = (v > 68'sd2147483647) || (v < -68'sd2147483648);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
		if (v > 68'sd2147483647)
			sat32 = 32'sh7FFFFFFF;
		else if (v < -68'sd2147483648)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction
endpackage
`default_nettype wire

// ===== rtl/dhj_cordic.sv =====
// Two-lane rotation-mode CORDIC with angle reduction, stepped by commands.
// Depends on dhj_pkg.
`default_nettype none
module dhj_cordic (
	input  wire logic               clk,
	input  wire dhj_pkg::cmd_t      cmd,
	input  wire logic signed [32:0] theta,
	input  wire logic signed [31:0] alpha,
	output logic                    in_range,
	output logic signed [32:0]      cos_t,
	output logic signed [32:0]      sin_t,
	output logic signed [32:0]      cos_a,
	output logic signed [32:0]      sin_a
);
	logic signed [34:0] th_q [2];
	logic signed [33:0] x_q  [2];
	logic signed [33:0] y_q  [2];
	logic signed [33:0] z_q  [2];
	logic               neg_q [2];
	logic [1:0]         lane_ok;
	logic signed [33:0] cs [2];
	logic signed [33:0] sn [2];

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic signed [34:0] fold;
		logic               fneg;
		logic signed [33:0] xs, ys, at;

		assign lane_ok[l] = (th_q[l] <= dhj_pkg::PI_Q28) && (th_q[l] >= -dhj_pkg::PI_Q28);
		assign xs = x_q[l] >>> cmd.step;
		assign ys = y_q[l] >>> cmd.step;
		assign at = $signed({2'b00, dhj_pkg::atan_q30(cmd.step)});
		assign cs[l] = neg_q[l] ? -x_q[l] : x_q[l];
		assign sn[l] = neg_q[l] ? -y_q[l] : y_q[l];

		always_comb begin
			if (th_q[l] > dhj_pkg::HALF_PI_Q28) begin
				fold = th_q[l] - dhj_pkg::PI_Q28;
				fneg = 1'b1;
			end else if (th_q[l] < -dhj_pkg::HALF_PI_Q28) begin
				fold = th_q[l] + dhj_pkg::PI_Q28;
				fneg = 1'b1;
			end else begin
				fold = th_q[l];
				fneg = 1'b0;
			end
		end

		always_ff @(posedge clk) begin
			case (cmd.op)
				dhj_pkg::OP_LOAD: begin
					th_q[l] <= (l == 0) ? {{2{theta[32]}}, theta} : {{3{alpha[31]}}, alpha};
				end
				dhj_pkg::OP_REDUCE: begin
					if (th_q[l] > dhj_pkg::PI_Q28)
						th_q[l] <= th_q[l] - dhj_pkg::TWO_PI_Q28;
					else if (th_q[l] < -dhj_pkg::PI_Q28)
						th_q[l] <= th_q[l] + dhj_pkg::TWO_PI_Q28;
				end
				dhj_pkg::OP_FOLD: begin
					z_q[l]   <= $signed({fold[31:0], 2'b00});
					x_q[l]   <= dhj_pkg::CORDIC_GAIN;
					y_q[l]   <= '0;
					neg_q[l] <= fneg;
				end
				dhj_pkg::OP_STEP: begin
					if (!z_q[l][33]) begin
						x_q[l] <= x_q[l] - ys;
						y_q[l] <= y_q[l] + xs;
						z_q[l] <= z_q[l] - at;
					end else begin
						x_q[l] <= x_q[l] + ys;
						y_q[l] <= y_q[l] - xs;
						z_q[l] <= z_q[l] + at;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign in_range = &lane_ok;
	assign cos_t = cs[0][32:0];
	assign sin_t = sn[0][32:0];
	assign cos_a = cs[1][32:0];
	assign sin_a = sn[1][32:0];
endmodule
`default_nettype wire

// ===== rtl/dhj_datapath.sv =====
// Datapath: frame state, link matrix, shared multiplier with accumulator,
// output register. Depends on dhj_pkg and dhj_cordic.
`default_nettype none
module dhj_datapath #(
	parameter int MAX_JOINTS = dhj_pkg::MAX_JOINTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire dhj_pkg::cmd_t    cmd,
	output dhj_pkg::status_t      status,
	input  wire logic [255:0]     in_data,
	input  wire logic             in_kind,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [199:0]          m_tdata,
	output logic [0:0]            m_tuser
);
	localparam logic signed [67:0] HALF29 = 68'sd536870912;
	localparam logic signed [67:0] HALF28 = 68'sd268435456;

	logic signed [31:0] fr_q [9];
	logic signed [31:0] fp_q [3];
	logic signed [31:0] ep_q [3];
	logic signed [31:0] rn_q [9];
	logic signed [31:0] pn_q [3];
	logic signed [31:0] lin_q [3];
	logic signed [32:0] rl_q [9];
	logic signed [31:0] pl_q [3];
	logic signed [32:0] ct_q, st_q, ca_q, sa_q;
	logic signed [31:0] len_q, off_q;
	logic [3:0]         col_q;
	logic               flag_q;
	logic signed [67:0] acc_q;
	logic signed [65:0] prod_s1;
	dhj_pkg::cmd_t      cmd_s1;

	logic signed [31:0] o_lin_q [3];
	logic signed [31:0] o_ang_q [3];
	logic [3:0]         o_col_q;
	logic               o_sat_q;
	logic               o_valid_q;

	logic               in_range;
	logic signed [32:0] cos_t, sin_t, cos_a, sin_a;
	logic signed [32:0] theta;
	logic signed [32:0] op_a, op_b;
	logic signed [32:0] dvec [3];
	logic signed [67:0] prod_x, rnd30, acc_n;
	logic [1:0]         ca_i, cb_i;

	assign theta = {in_data[127], in_data[127:96]} + {in_data[159], in_data[159:128]};

	dhj_cordic u_cordic (
		.clk      (clk),
		.cmd      (cmd),
		.theta    (theta),
		.alpha    (in_data[191:160]),
		.in_range (in_range),
		.cos_t    (cos_t),
		.sin_t    (sin_t),
		.cos_a    (cos_a),
		.sin_a    (sin_a)
	);

	for (genvar c = 0; c < 3; c++) begin : g_dist
		assign dvec[c] = {ep_q[c][31], ep_q[c]} - {pn_q[c][31], pn_q[c]};
	end

	// cross term pairing: first term z[c+1]*d[c+2], second z[c+2]*d[c+1]
	assign ca_i = dhj_pkg::next3(cmd.ri);
	assign cb_i = dhj_pkg::next3(ca_i);

	always_comb begin
		op_a = '0;
		op_b = '0;
		case (cmd.op)
			dhj_pkg::OP_LINK: begin
				case (cmd.step)
					5'd0: begin op_a = st_q; op_b = ca_q; end
					5'd1: begin op_a = ct_q; op_b = ca_q; end
					5'd2: begin op_a = st_q; op_b = sa_q; end
					5'd3: begin op_a = ct_q; op_b = sa_q; end
					5'd4: begin op_a = {off_q[31], off_q}; op_b = sa_q; end
					default: begin op_a = {off_q[31], off_q}; op_b = ca_q; end
				endcase
			end
			dhj_pkg::OP_ROT: begin
				op_a = {fr_q[dhj_pkg::idx9(cmd.ri, cmd.rk)][31],
					fr_q[dhj_pkg::idx9(cmd.ri, cmd.rk)]};
				op_b = rl_q[dhj_pkg::idx9(cmd.rk, cmd.rj)];
			end
			dhj_pkg::OP_POS: begin
				op_a = {fr_q[dhj_pkg::idx9(cmd.ri, cmd.rj)][31],
					fr_q[dhj_pkg::idx9(cmd.ri, cmd.rj)]};
				op_b = {pl_q[cmd.rj][31], pl_q[cmd.rj]};
			end
			dhj_pkg::OP_CROSS: begin
				if (cmd.rk == 2'd0) begin
					op_a = {rn_q[dhj_pkg::idx9(ca_i, 2'd2)][31], rn_q[dhj_pkg::idx9(ca_i, 2'd2)]};
					op_b = dvec[cb_i];
				end else begin
					op_a = {rn_q[dhj_pkg::idx9(cb_i, 2'd2)][31], rn_q[dhj_pkg::idx9(cb_i, 2'd2)]};
					op_b = dvec[ca_i];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '{op: dhj_pkg::OP_NOP, step: '0, ri: '0, rj: '0, rk: '0};
		end else begin
			cmd_s1 <= cmd;
		end
	end

	assign prod_x = {{2{prod_s1[65]}}, prod_s1};
	assign rnd30  = (prod_x + HALF29) >>> 30;

	always_comb begin
		case (cmd_s1.op)
			dhj_pkg::OP_ROT:   acc_n = ((cmd_s1.rk == 2'd0) ? 68'sd0 : acc_q) + prod_x;
			dhj_pkg::OP_POS:   acc_n = ((cmd_s1.rj == 2'd0) ?
				{{36{fp_q[cmd_s1.ri][31]}}, fp_q[cmd_s1.ri]} : acc_q) + rnd30;
			dhj_pkg::OP_CROSS: acc_n = (cmd_s1.rk == 2'd0) ? (prod_x >>> 1) :
				acc_q - (prod_x >>> 1);
			default:           acc_n = acc_q;
		endcase
	end

	// second stage: accumulate the registered product of the previous cycle's command
	always_ff @(posedge clk) begin
		acc_q <= acc_n;
		case (cmd_s1.op)
			dhj_pkg::OP_LINK: begin
				case (cmd_s1.step)
					5'd0: rl_q[3] <= rnd30[32:0];
					5'd1: rl_q[4] <= rnd30[32:0];
					5'd2: rl_q[6] <= rnd30[32:0];
					5'd3: rl_q[7] <= rnd30[32:0];
					5'd4: pl_q[1] <= dhj_pkg::sat32(-rnd30);
					default: pl_q[2] <= dhj_pkg::sat32(rnd30);
				endcase
			end
			dhj_pkg::OP_ROT: begin
				if (cmd_s1.rk == 2'd2)
					rn_q[dhj_pkg::idx9(cmd_s1.ri, cmd_s1.rj)] <=
						dhj_pkg::sat32((acc_n + HALF29) >>> 30);
			end
			dhj_pkg::OP_POS: begin
				if (cmd_s1.rj == 2'd2)
					pn_q[cmd_s1.ri] <= dhj_pkg::sat32(acc_n);
			end
			dhj_pkg::OP_CROSS: begin
				if (cmd_s1.rk == 2'd1)
					lin_q[cmd_s1.ri] <= dhj_pkg::sat32((acc_n + HALF28) >>> 29);
			end
			default: begin
			end
		endcase
		if (cmd.op == dhj_pkg::OP_LOAD) begin
			len_q <= in_data[223:192];
			off_q <= in_data[255:224];
		end
		if (cmd.op == dhj_pkg::OP_CAPTURE) begin
			ct_q    <= cos_t;
			st_q    <= sin_t;
			ca_q    <= cos_a;
			sa_q    <= sin_a;
			rl_q[0] <= cos_t;
			rl_q[1] <= -sin_t;
			rl_q[2] <= '0;
			rl_q[5] <= -sin_a;
			rl_q[8] <= cos_a;
			pl_q[0] <= len_q;
		end
	end

	// architectural frame state, counter and saturation flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < 9; n++)
				fr_q[n] <= (n % 4 == 0) ? dhj_pkg::ONE_Q30 : 32'sd0;
			for (int n = 0; n < 3; n++) begin
				fp_q[n] <= '0;
				ep_q[n] <= '0;
			end
			col_q  <= '0;
			flag_q <= 1'b0;
		end else begin
			if (cmd.op == dhj_pkg::OP_LOAD && !in_kind) begin
				for (int n = 0; n < 9; n++)
					fr_q[n] <= (n % 4 == 0) ? dhj_pkg::ONE_Q30 : 32'sd0;
				for (int n = 0; n < 3; n++) begin
					fp_q[n] <= '0;
					ep_q[n] <= in_data[32*n +: 32];
				end
				col_q <= '0;
			end
			if (cmd.op == dhj_pkg::OP_CAPTURE)
				flag_q <= 1'b0;
			else if ((cmd_s1.op == dhj_pkg::OP_LINK && cmd_s1.step == 5'd4
					&& dhj_pkg::over32(-rnd30))
				|| (cmd_s1.op == dhj_pkg::OP_LINK && cmd_s1.step == 5'd5
					&& dhj_pkg::over32(rnd30))
				|| (cmd_s1.op == dhj_pkg::OP_POS && cmd_s1.rj == 2'd2
					&& dhj_pkg::over32(acc_n))
				|| (cmd_s1.op == dhj_pkg::OP_CROSS && cmd_s1.rk == 2'd1
					&& dhj_pkg::over32((acc_n + HALF28) >>> 29)))
				flag_q <= 1'b1;
			if (cmd.op == dhj_pkg::OP_COMMIT) begin
				for (int n = 0; n < 9; n++)
					fr_q[n] <= rn_q[n];
				for (int n = 0; n < 3; n++)
					fp_q[n] <= pn_q[n];
				if ({1'b0, col_q} < 5'(MAX_JOINTS - 1))
					col_q <= col_q + 4'd1;
			end
		end
	end

	// output register, holds while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			o_valid_q <= 1'b0;
		else if (cmd.op == dhj_pkg::OP_COMMIT)
			o_valid_q <= 1'b1;
		else if (m_tready)
			o_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.op == dhj_pkg::OP_COMMIT) begin
			for (int n = 0; n < 3; n++) begin
				o_lin_q[n] <= lin_q[n];
				o_ang_q[n] <= rn_q[3*n + 2];
			end
			o_col_q <= col_q;
			o_sat_q <= flag_q;
		end
	end

	assign status.in_range = in_range;
	assign status.out_busy = o_valid_q && !m_tready;
	assign m_tvalid = o_valid_q;
	assign m_tdata  = {4'b0000, o_col_q, o_ang_q[2], o_ang_q[1], o_ang_q[0],
		o_lin_q[2], o_lin_q[1], o_lin_q[0]};
	assign m_tuser  = o_sat_q;
endmodule
`default_nettype wire

// ===== rtl/dhj_ctrl.sv =====
// Sequencer: walks one joint item through reduction, CORDIC, link products,
// frame chaining and cross product. Depends on dhj_pkg and the assert header.
`default_nettype none
`include "dh_geometric_jacobian_column_unit_assert.svh"
module dhj_ctrl #(
	parameter int CORDIC_STEPS = dhj_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic             in_kind,
	input  wire dhj_pkg::status_t status,
	output dhj_pkg::cmd_t         cmd
);
	typedef enum logic [10:0] {
		S_IDLE  = 11'b00000000001,
		S_RED   = 11'b00000000010,
		S_ITER  = 11'b00000000100,
		S_CAP   = 11'b00000001000,
		S_LINK  = 11'b00000010000,
		S_ROT   = 11'b00000100000,
		S_POS   = 11'b00001000000,
		S_GAP   = 11'b00010000000,
		S_CROSS = 11'b00100000000,
		S_DRAIN = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;
	logic [1:0] i_q, j_q, k_q, i_d, j_d, k_d;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		i_d     = i_q;
		j_d     = j_q;
		k_d     = k_q;
		cmd     = '{op: dhj_pkg::OP_NOP, step: cnt_q, ri: i_q, rj: j_q, rk: k_q};
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op = dhj_pkg::OP_LOAD;
					if (in_kind)
						state_d = S_RED;
				end
			end
			S_RED: begin
				if (status.in_range) begin
					cmd.op  = dhj_pkg::OP_FOLD;
					cnt_d   = '0;
					state_d = S_ITER;
				end else begin
					cmd.op = dhj_pkg::OP_REDUCE;
				end
			end
			S_ITER: begin
				cmd.op = dhj_pkg::OP_STEP;
				if (cnt_q == 5'(CORDIC_STEPS - 1))
					state_d = S_CAP;
				else
					cnt_d = cnt_q + 5'd1;
			end
			S_CAP: begin
				cmd.op  = dhj_pkg::OP_CAPTURE;
				cnt_d   = '0;
				state_d = S_LINK;
			end
			S_LINK: begin
				cmd.op = dhj_pkg::OP_LINK;
				if (cnt_q == 5'd5) begin
					i_d = '0;
					j_d = '0;
					k_d = '0;
					state_d = S_ROT;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			S_ROT: begin
				cmd.op = dhj_pkg::OP_ROT;
				k_d = dhj_pkg::next3(k_q);
				if (k_q == 2'd2) begin
					j_d = dhj_pkg::next3(j_q);
					if (j_q == 2'd2) begin
						i_d = dhj_pkg::next3(i_q);
						if (i_q == 2'd2)
							state_d = S_POS;
					end
				end
			end
			S_POS: begin
				cmd.op = dhj_pkg::OP_POS;
				j_d = dhj_pkg::next3(j_q);
				if (j_q == 2'd2) begin
					i_d = dhj_pkg::next3(i_q);
					if (i_q == 2'd2)
						state_d = S_GAP;
				end
			end
			S_GAP: begin
				// last position entry lands before the distances are read
				k_d     = '0;
				state_d = S_CROSS;
			end
			S_CROSS: begin
				cmd.op = dhj_pkg::OP_CROSS;
				k_d = (k_q == 2'd0) ? 2'd1 : 2'd0;
				if (k_q == 2'd1) begin
					i_d = dhj_pkg::next3(i_q);
					if (i_q == 2'd2)
						state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!status.out_busy) begin
					cmd.op  = dhj_pkg::OP_COMMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			i_q     <= i_d;
			j_q     <= j_d;
			k_q     <= k_d;
		end
	end

	assign s_tready = (state_q == S_IDLE);

	`DHJ_ASSERT_NOW(a_commit_free, cmd.op == dhj_pkg::OP_COMMIT, !status.out_busy, "commit into busy output")
	`DHJ_ASSERT_NEXT(a_joint_starts, s_tvalid && s_tready && in_kind, state_q == S_RED, "joint item not started")
	`DHJ_ASSERT_NOW(a_iter_bound, state_q == S_ITER, cnt_q <= 5'(CORDIC_STEPS - 1), "CORDIC step overrun")
endmodule
`default_nettype wire

// ===== rtl/dh_geometric_jacobian_column_unit.sv =====
// Top level of the Jacobian column unit: sequencer plus datapath.
// Depends on dhj_pkg, dhj_ctrl, dhj_datapath.
//
// Usage:
//  Input channel s_*: one item per handshake. s_tuser is the kind: 0 loads the
//  end-effector position and resets the frame to identity (no result), 1 asks
//  for the next Jacobian column using the link fields in s_tdata.
//  Output channel m_*: one result per joint item, in order.
//  Sequence: a start item is taken in the idle state alone. A joint item runs
//  through up to 3 angle reductions, CORDIC_STEPS iterations of the two-lane
//  CORDIC and the capture state, then 48 passes through the single shared 33x33
//  multiplier (link, rotation, position and cross products, with the gap state
//  before the cross products), then the drain and done states before the
//  commit.
//  s_tready is high only while no item is in work.
//  A finished result sits in the output register; the next item is accepted
//  meanwhile, and it waits before its own result if m_tready stays low.
//  Reset: identity frame, zero end position, column counter zero, no result.
`default_nettype none
module dh_geometric_jacobian_column_unit #(
	parameter int MAX_JOINTS   = dhj_pkg::MAX_JOINTS_DEF,
	parameter int CORDIC_STEPS = dhj_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// end_pos_x, end_pos_y, end_pos_z, joint_angle, angle_offset,
	// link_twist, link_length, link_offset
	input  wire logic [255:0] s_tdata,
	// kind
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// linear_x, linear_y, linear_z, angular_x, angular_y, angular_z,
	// column_index, zero pad
	output logic [199:0]      m_tdata,
	// saturated
	output logic [0:0]        m_tuser
);
	dhj_pkg::cmd_t    cmd;
	dhj_pkg::status_t status;

	dhj_ctrl #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.in_kind  (s_tuser[0]),
		.status   (status),
		.cmd      (cmd)
	);

	dhj_datapath #(
		.MAX_JOINTS (MAX_JOINTS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (s_tdata),
		.in_kind  (s_tuser[0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the Jacobian column unit: random and directed link items,
// in-bench fixed-point predictor of the frame chain and column. Depends on dhj_pkg and the RTL.
module tb_top;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [255:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [199:0] m_tdata;
	logic [0:0] m_tuser;

	localparam int SATURATE_TOP = 15;

	typedef struct {
		logic [0:0]   kind;
		logic [255:0] fields;
	} link_item_t;

	typedef struct {
		logic [199:0] column;
		logic [0:0]   sat;
	} column_t;

	link_item_t pending_links[$];
	column_t expected_columns[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet_phase = 1'b0;
	bit stimulus_done = 1'b0;

	// predictor state
	longint rot[9];
	longint pos[3];
	longint end_at[3];
	int col_count;

	logic [31:0] n_vals[10] = '{32'sd843314857, -32'sd843314857, 32'sd843314858,
		-32'sd843314858, 32'sd421657428, -32'sd421657428, 32'sd421657429,
		-32'sd421657429, 32'h7FFFFFFF, 32'h80000000};

	dh_geometric_jacobian_column_unit DUT (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic longint clip32(longint v, ref bit flag);
		if (v > 64'sd2147483647) begin
			flag = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			flag = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	function automatic longint round_q30(longint a, longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic void cordic_sincos(longint th, output longint c, output longint s);
		longint x, y, z, nx;
		bit neg;
		x = dhj_pkg::CORDIC_GAIN;
		y = 0;
		neg = 1'b0;
		while (th > dhj_pkg::PI_Q28) th -= dhj_pkg::TWO_PI_Q28;
		while (th < -dhj_pkg::PI_Q28) th += dhj_pkg::TWO_PI_Q28;
		if (th > dhj_pkg::HALF_PI_Q28) begin
			th -= dhj_pkg::PI_Q28;
			neg = 1'b1;
		end else if (th < -dhj_pkg::HALF_PI_Q28) begin
			th += dhj_pkg::PI_Q28;
			neg = 1'b1;
		end
		z = th * 4;
		for (int i = 0; i < dhj_pkg::CORDIC_STEPS_DEF; i++) begin
			longint t;
			t = longint'(dhj_pkg::atan_q30(5'(i)));
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= t;
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += t;
			end
			x = nx;
		end
		c = neg ? -x : x;
		s = neg ? -y : y;
	endfunction

	function automatic void reset_frame();
		for (int i = 0; i < 9; i++) rot[i] = (i % 4 == 0) ? 64'sd1073741824 : 0;
		for (int i = 0; i < 3; i++) pos[i] = 0;
		col_count = 0;
	endfunction

	function automatic void predict_column(link_item_t it);
		longint ct, st, ca, sa, d, acc, sum;
		longint rl[9], pl[3], rn[9], pn[3], zx[3], dvec[3], lin[3];
		bit flag;
		column_t res;
		flag = 1'b0;
		if (it.kind[0] == 1'b0) begin
			reset_frame();
			for (int i = 0; i < 3; i++) end_at[i] = longint'($signed(it.fields[32*i +: 32]));
			return;
		end
		cordic_sincos(longint'($signed(it.fields[96 +: 32])) +
			longint'($signed(it.fields[128 +: 32])), ct, st);
		cordic_sincos(longint'($signed(it.fields[160 +: 32])), ca, sa);
		d = longint'($signed(it.fields[224 +: 32]));
		rl[0] = ct; rl[1] = -st; rl[2] = 0;
		rl[3] = round_q30(st, ca); rl[4] = round_q30(ct, ca); rl[5] = -sa;
		rl[6] = round_q30(st, sa); rl[7] = round_q30(ct, sa); rl[8] = ca;
		pl[0] = longint'($signed(it.fields[192 +: 32]));
		pl[1] = clip32(-round_q30(d, sa), flag);
		pl[2] = clip32(round_q30(d, ca), flag);
		for (int i = 0; i < 3; i++) begin
			acc = pos[i];
			for (int j = 0; j < 3; j++) begin
				bit dummy;
				sum = 0;
				for (int k = 0; k < 3; k++) sum += rot[i*3+k] * rl[k*3+j];
				rn[i*3+j] = clip32((sum + (64'sd1 <<< 29)) >>> 30, dummy);
				acc += round_q30(rot[i*3+j], pl[j]);
			end
			pn[i] = clip32(acc, flag);
		end
		for (int i = 0; i < 9; i++) rot[i] = rn[i];
		for (int i = 0; i < 3; i++) begin
			pos[i] = pn[i];
			zx[i] = rn[i*3+2];
			dvec[i] = end_at[i] - pn[i];
		end
		lin[0] = ((zx[1] * dvec[2]) >>> 1) - ((zx[2] * dvec[1]) >>> 1);
		lin[1] = ((zx[2] * dvec[0]) >>> 1) - ((zx[0] * dvec[2]) >>> 1);
		lin[2] = ((zx[0] * dvec[1]) >>> 1) - ((zx[1] * dvec[0]) >>> 1);
		res.column = '0;
		for (int i = 0; i < 3; i++) begin
			lin[i] = clip32((lin[i] + (64'sd1 <<< 28)) >>> 29, flag);
			res.column[32*i +: 32] = lin[i][31:0];
			res.column[96 + 32*i +: 32] = zx[i][31:0];
		end
		res.column[192 +: 4] = 4'(col_count);
		res.sat = flag;
		if (col_count < SATURATE_TOP) col_count++;
		expected_columns.push_back(res);
	endfunction

	function automatic logic [31:0] rand_angle(int mode);
		case (mode)
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 1686629713)) - 843314857);
			default: return 32'($signed($urandom_range(0, 200000000)) - 100000000);
		endcase
	endfunction

	function automatic logic [31:0] rand_length(int mode);
		case (mode)
			0: return $urandom;
			default: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	function automatic link_item_t make_joint(int mode);
		link_item_t it;
		it.kind = 1'b1;
		it.fields = '0;
		for (int i = 0; i < 3; i++) it.fields[32*i +: 32] = $urandom;
		it.fields[96 +: 32] = rand_angle(mode);
		it.fields[128 +: 32] = rand_angle(mode);
		it.fields[160 +: 32] = rand_angle(mode);
		it.fields[192 +: 32] = rand_length(mode);
		it.fields[224 +: 32] = rand_length(mode);
		return it;
	endfunction

	function automatic link_item_t make_start(int mode);
		link_item_t it;
		it.kind = 1'b0;
		it.fields = '0;
		for (int i = 0; i < 3; i++) it.fields[32*i +: 32] = rand_length(mode);
		for (int i = 3; i < 8; i++) it.fields[32*i +: 32] = $urandom;
		return it;
	endfunction

	function automatic link_item_t fill_joint(logic [31:0] v);
		link_item_t it;
		it.kind = 1'b1;
		it.fields = {8{v}};
		return it;
	endfunction

	initial begin
		link_item_t it;
		int n;
		// predictor starts from the reset frame, end position at zero
		reset_frame();
		for (int i = 0; i < 3; i++) end_at[i] = 0;
		// joint before any start runs on the reset frame
		pending_links.push_back(make_joint(2));
		pending_links.push_back(fill_joint(32'h7FFFFFFF));
		pending_links.push_back(fill_joint(32'h80000000));
		pending_links.push_back(fill_joint(32'h00000000));
		pending_links.push_back(fill_joint(32'hFFFFFFFF));
		it = make_start(0);
		it.fields[95:0] = {32'h80000000, 32'h7FFFFFFF, 32'h80000000};
		pending_links.push_back(it);
		// large link offsets and lengths push the frame position into clipping
		for (int i = 0; i < 4; i++) begin
			it = fill_joint(32'h7FFFFFFF);
			it.fields[96 +: 96] = {3{32'(i * 210000000)}};
			pending_links.push_back(it);
		end
		// angles on the fold boundaries
		it = make_start(1);
		pending_links.push_back(it);
		foreach (n_vals[i]) begin
			it = make_joint(1);
			it.fields[96 +: 32] = n_vals[i];
			it.fields[128 +: 32] = 32'h0;
			it.fields[160 +: 32] = n_vals[i];
			pending_links.push_back(it);
		end
		// more than sixteen joints: index stays at the top
		for (int i = 0; i < 17; i++) pending_links.push_back(make_joint(2));
		n = 0;
		while (n < 800) begin
			int mode;
			int joints;
			mode = $urandom_range(0, 3);
			if (mode == 3) mode = 2;
			pending_links.push_back(make_start(mode));
			joints = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 7);
			for (int j = 0; j < joints; j++) begin
				pending_links.push_back(make_joint(($urandom_range(0, 4) == 0) ? 0 : mode));
			end
			n += joints + 1;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	// quiet phase: no random gaps on either channel for a window in the middle of the run
	always @(posedge clk) begin
		quiet_phase <= (expected_columns.size() + pending_links.size() < 500) &&
			(pending_links.size() > 300);
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_column(pending_links.pop_front());
			end
			if (!s_tvalid || s_tready) begin
				if (pending_links.size() > 0
						&& (quiet_phase || $urandom_range(0, 99) >= 31)) begin
					it_drive();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	task automatic it_drive();
		link_item_t it;
		it = pending_links[0];
		s_tvalid <= 1'b1;
		s_tdata <= it.fields;
		s_tuser <= it.kind;
	endtask

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				column_t want;
				if (expected_columns.size() == 0) begin
					$display("%0t: unexpected column %h sat %b", $time, m_tdata, m_tuser);
					errors++;
				end else begin
					want = expected_columns.pop_front();
					for (int f = 0; f < 6; f++) begin
						if (m_tdata[32*f +: 32] !== want.column[32*f +: 32]) begin
							$display("%0t: field %0d expected %h actual %h", $time, f,
								want.column[32*f +: 32], m_tdata[32*f +: 32]);
							errors++;
						end
					end
					if (m_tdata[199:192] !== want.column[199:192]) begin
						$display("%0t: column index expected %h actual %h", $time,
							want.column[199:192], m_tdata[199:192]);
						errors++;
					end
					if (m_tuser !== want.sat) begin
						$display("%0t: saturated expected %b actual %b", $time, want.sat, m_tuser);
						errors++;
					end
				end
			end
			m_tready <= quiet_phase || ($urandom_range(0, 99) >= 31);
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		wait (arst_n);
		fork
			begin
				wait (pending_links.size() == 0 && !s_tvalid && expected_columns.size() == 0);
				repeat (200) @(posedge clk);
				if (errors == 0 && expected_columns.size() == 0 && !m_tvalid) begin
					$display("Testbench completed without errors");
				end else begin
					$display("Testbench completed WITH ERRORS");
				end
				$finish;
			end
			begin
				wait (idle_cycles >= 5000);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		join
	end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/dhj_pkg.sv
rtl/dhj_cordic.sv
rtl/dhj_datapath.sv
rtl/dhj_ctrl.sv
rtl/dh_geometric_jacobian_column_unit.sv
tb/sv/tb_top.sv
